// ===== rtl/ftc_pkg.sv =====
// Package: shared types, constants, register indexes and the plane distance function of the frustum clipper.
`default_nettype none
package ftc_pkg;
  localparam int MaxVerts = 10;
  localparam int IdxW = 4;
  localparam int CntW = 5;
  localparam int NumPlanes = 6;
  localparam int ResultLimit = 7;

  typedef enum logic [2:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_NEAR  = 3'd4,
    REG_FAR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vert_t;

  typedef struct packed {
    vert_t v0;
    vert_t v1;
    vert_t v2;
  } tri_t;

  typedef struct packed {
    logic [14:0] cx;
    logic [14:0] sx;
    logic [14:0] cy;
    logic [14:0] sy;
    logic [30:0] near_d;
    logic [30:0] far_d;
  } cfg_t;

  typedef struct packed {
    vert_t a;
    vert_t b;
    vert_t c;
    logic  tvalid;
    logic  last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PSTART,
    ST_DPREV,
    ST_EDGE,
    ST_DIV,
    ST_MUL,
    ST_PUSHI,
    ST_PUSHC,
    ST_COPY,
    ST_EMIT,
    ST_WAIT
  } st_t;

  // Signed distance of a vertex to a plane, scale 2^-30.
  function automatic logic signed [49:0] plane_dist(input logic [2:0] p,
                                                    input vert_t v,
                                                    input cfg_t c);
    logic signed [49:0] xc, zs, yc, zsy, zn, fz;
    begin
      xc  = 50'(v.x * $signed({1'b0, c.cx}));
      zs  = 50'(v.z * $signed({1'b0, c.sx}));
      yc  = 50'(v.y * $signed({1'b0, c.cy}));
      zsy = 50'(v.z * $signed({1'b0, c.sy}));
      zn  = 50'(($signed({{18{v.z[31]}}, v.z}) - $signed({19'd0, c.near_d})) <<< 14);
      fz  = 50'(($signed({19'd0, c.far_d}) - $signed({{18{v.z[31]}}, v.z})) <<< 14);
      unique case (p)
        3'd0:    plane_dist = xc + zs;
        3'd1:    plane_dist = zs - xc;
        3'd2:    plane_dist = zsy - yc;
        3'd3:    plane_dist = yc + zsy;
        3'd4:    plane_dist = zn;
        default: plane_dist = fz;
      endcase
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/frustum_triangle_clipper.sv =====
// Top level of the frustum triangle clipper.
// One triangle word is clipped against left, right, top, bottom, near and far
// planes and leaves as a fan of up to seven triangle words, the last marked;
// a triangle clipped away gives one word with triangle_valid low. A two-word
// input queue decouples intake from the clipping engine. Each plane pass runs
// the setup states PSTART and DPREV, an edge test and a push per vertex, a
// divider run and three interpolation steps for each edge that crosses the
// plane, and a copy of the kept vertices (at least one entry) back to the
// list; each output word is registered and then held until it is taken.
`default_nettype none
module frustum_triangle_clipper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] v0_x, v0_y, v0_z,
  input  wire logic signed [31:0] v1_x, v1_y, v1_z,
  input  wire logic signed [31:0] v2_x, v2_y, v2_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_a_x, out_a_y, out_a_z,
  output logic signed [31:0] out_b_x, out_b_y, out_b_z,
  output logic signed [31:0] out_c_x, out_c_y, out_c_z,
  output logic             triangle_valid,
  output logic             last_triangle
);
  ftc_pkg::cfg_t cfg;
  ftc_pkg::tri_t tin, tq;
  ftc_pkg::res_t res;
  logic          q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cx: 15'd11585, sx: 15'd11585, cy: 15'd11585, sy: 15'd11585,
               near_d: 31'd65536, far_d: 31'd1310720000};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ftc_pkg::REG_COS_X: cfg.cx <= cfg_data[14:0];
        ftc_pkg::REG_SIN_X: cfg.sx <= cfg_data[14:0];
        ftc_pkg::REG_COS_Y: cfg.cy <= cfg_data[14:0];
        ftc_pkg::REG_SIN_Y: cfg.sy <= cfg_data[14:0];
        ftc_pkg::REG_NEAR:  cfg.near_d <= cfg_data;
        ftc_pkg::REG_FAR:   cfg.far_d <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tin = '{v0: '{v0_x, v0_y, v0_z}, v1: '{v1_x, v1_y, v1_z},
                 v2: '{v2_x, v2_y, v2_z}};

  ftc_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(tin), .out_valid(q_valid), .out_ready(q_ready), .out_data(tq)
  );

  ftc_engine u_eng (
    .clk(clk), .rst(rst), .cfg(cfg), .tri_valid(q_valid), .tri_ready(q_ready),
    .tri_in(tq), .res_valid(out_valid), .res_ready(out_ready), .res(res)
  );

  assign out_a_x = res.a.x; assign out_a_y = res.a.y; assign out_a_z = res.a.z;
  assign out_b_x = res.b.x; assign out_b_y = res.b.y; assign out_b_z = res.b.z;
  assign out_c_x = res.c.x; assign out_c_y = res.c.y; assign out_c_z = res.c.z;
  assign triangle_valid = res.tvalid;
  assign last_triangle  = res.last;
endmodule
`default_nettype wire

// ===== rtl/ftc_fifo.sv =====
// Two-entry queue of accepted triangles between front and back.
`default_nettype none
module ftc_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ftc_pkg::tri_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ftc_pkg::tri_t       out_data
);
  ftc_pkg::tri_t mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = mem[rp];

  // storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_data;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ftc_div.sv =====
// Restoring divider: floor(a * 2^30 / den), one quotient bit per cycle.
`default_nettype none
module ftc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [50:0] num,
  input  wire logic [50:0] den,
  output logic             done,
  output logic [30:0]      quo
);
  logic [51:0] rem;
  logic [50:0] dreg;
  logic [4:0]  step;
  logic        busy;
  logic [51:0] sh;

  assign sh = {rem[50:0], 1'b0};

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd0;
        dreg <= den;
        if (num >= den) begin
          quo <= 31'd1; rem <= {1'b0, num - den};
        end else begin
          quo <= 31'd0; rem <= {1'b0, num};
        end
      end else if (busy) begin
        if (sh >= {1'b0, dreg}) begin
          rem <= sh - {1'b0, dreg}; quo <= {quo[29:0], 1'b1};
        end else begin
          rem <= sh; quo <= {quo[29:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'd29) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ftc_engine.sv =====
// Back end: clip passes over the vertex list, then fan emission.
`default_nettype none
module ftc_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ftc_pkg::cfg_t cfg,
  input  wire logic          tri_valid,
  output logic               tri_ready,
  input  wire ftc_pkg::tri_t tri_in,
  output logic               res_valid,
  input  wire logic          res_ready,
  output ftc_pkg::res_t      res
);
  ftc_pkg::vert_t vs [ftc_pkg::MaxVerts];
  ftc_pkg::vert_t is [ftc_pkg::MaxVerts];
  ftc_pkg::st_t   st, st_next;
  logic [2:0]                  plane;
  logic [ftc_pkg::CntW-1:0]    n, i, outn;
  logic [1:0]                  ax;
  logic signed [49:0]          dp, dc;
  ftc_pkg::vert_t              pv, cv, iv;
  logic [2:0]                  tri_k;
  logic [2:0]                  ntri;
  logic                        div_start, div_done;
  logic                        div_go, cross_now;
  logic [30:0]                 tq;
  logic [50:0]                 ma, mb;
  logic signed [32:0]          delta;
  logic [32:0]                 mdelta;
  logic [63:0]                 prod;
  logic [33:0]                 rnd;
  logic signed [31:0]          pcomp, icomp;
  logic                        in_c, in_p;
  logic signed [49:0]          pdist;

  ftc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(ma), .den(ma + mb),
    .done(div_done), .quo(tq)
  );

  assign pdist = ftc_pkg::plane_dist(plane, cv, cfg);
  assign in_c = ~dc[49];
  assign in_p = ~dp[49];
  // current vertex sits on the other side of the plane than the previous one
  assign cross_now = (~pdist[49]) != in_p;
  assign ma   = dp[49] ? 51'(-dp) : 51'(dp);
  assign mb   = dc[49] ? 51'(-dc) : 51'(dc);

  // per-axis interpolation
  always_comb begin
    unique case (ax)
      2'd0:    begin pcomp = pv.x; delta = 33'(cv.x) - 33'(pv.x); end
      2'd1:    begin pcomp = pv.y; delta = 33'(cv.y) - 33'(pv.y); end
      default: begin pcomp = pv.z; delta = 33'(cv.z) - 33'(pv.z); end
    endcase
    mdelta = delta[32] ? 33'(-delta) : 33'(delta);
    rnd    = 34'((prod + 64'd536870912) >> 30);
    icomp  = delta[32] ? 32'(pcomp - 32'(rnd)) : 32'(pcomp + 32'(rnd));
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ftc_pkg::ST_IDLE:   if (tri_valid) st_next = ftc_pkg::ST_LOAD;
      ftc_pkg::ST_LOAD:   st_next = ftc_pkg::ST_PSTART;
      ftc_pkg::ST_PSTART: begin
        if (n < 5'd3 || plane == 3'(ftc_pkg::NumPlanes)) st_next = ftc_pkg::ST_EMIT;
        else st_next = ftc_pkg::ST_DPREV;
      end
      ftc_pkg::ST_DPREV:  st_next = ftc_pkg::ST_EDGE;
      ftc_pkg::ST_EDGE:   begin
        if (cross_now) st_next = ftc_pkg::ST_DIV;
        else st_next = ftc_pkg::ST_PUSHC;
      end
      ftc_pkg::ST_DIV:    if (div_done) st_next = ftc_pkg::ST_MUL;
      ftc_pkg::ST_MUL:    st_next = ftc_pkg::ST_PUSHI;
      ftc_pkg::ST_PUSHI:  if (ax == 2'd2) st_next = ftc_pkg::ST_PUSHC;
                          else st_next = ftc_pkg::ST_MUL;
      ftc_pkg::ST_PUSHC:  begin
        if (i + 5'd1 == n) st_next = ftc_pkg::ST_COPY;
        else st_next = ftc_pkg::ST_EDGE;
      end
      ftc_pkg::ST_COPY:   if (i + 5'd1 >= outn) st_next = ftc_pkg::ST_PSTART;
      ftc_pkg::ST_EMIT:   st_next = ftc_pkg::ST_WAIT;
      ftc_pkg::ST_WAIT:   begin
        if (res_ready) begin
          if (res.last) st_next = ftc_pkg::ST_IDLE;
          else st_next = ftc_pkg::ST_EMIT;
        end
      end
      default:            st_next = ftc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tri_ready = (st == ftc_pkg::ST_IDLE);
    res_valid = (st == ftc_pkg::ST_WAIT);
    div_start = div_go;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ftc_pkg::ST_IDLE;
      div_go <= 1'b0;
    end else begin
      st <= st_next;
      // divider starts once both distances are registered
      div_go <= (st == ftc_pkg::ST_EDGE) && cross_now;
    end
    unique case (st)
      ftc_pkg::ST_IDLE: if (tri_valid) begin
        vs[0] <= tri_in.v0; vs[1] <= tri_in.v1; vs[2] <= tri_in.v2;
        n <= 5'd3; plane <= 3'd0;
      end
      ftc_pkg::ST_LOAD: ;
      ftc_pkg::ST_PSTART: begin
        cv   <= vs[4'(n - 5'd1)];
        i    <= 5'd0; outn <= 5'd0;
        tri_k <= 3'd0;
        ntri <= (n - 5'd2 > 5'(ftc_pkg::ResultLimit)) ? 3'(ftc_pkg::ResultLimit)
                                                       : 3'(n - 5'd2);
      end
      ftc_pkg::ST_DPREV: begin
        dp <= pdist; pv <= cv; cv <= vs[4'(i)];
      end
      ftc_pkg::ST_EDGE: begin
        dc <= pdist; ax <= 2'd0;
      end
      ftc_pkg::ST_DIV: ;
      ftc_pkg::ST_MUL: prod <= 64'(mdelta) * 64'(tq);
      ftc_pkg::ST_PUSHI: begin
        unique case (ax)
          2'd0:    iv.x <= icomp;
          2'd1:    iv.y <= icomp;
          default: iv.z <= icomp;
        endcase
        if (ax == 2'd2) begin
          if (outn < 5'(ftc_pkg::MaxVerts)) begin
            is[4'(outn)] <= '{x: iv.x, y: iv.y, z: icomp};
            outn <= outn + 5'd1;
          end
        end
        ax <= ax + 2'd1;
      end
      ftc_pkg::ST_PUSHC: begin
        if (in_c && outn < 5'(ftc_pkg::MaxVerts)) begin
          is[4'(outn)] <= cv;
          outn <= outn + 5'd1;
        end
        dp <= dc; pv <= cv;
        if (i + 5'd1 == n) i <= 5'd0;
        else begin
          i  <= i + 5'd1;
          cv <= vs[4'(i + 5'd1)];
        end
      end
      ftc_pkg::ST_COPY: begin
        if (outn != 5'd0) vs[4'(i)] <= is[4'(i)];
        i <= i + 5'd1;
        if (i + 5'd1 >= outn) begin
          n <= outn; plane <= plane + 3'd1;
        end
      end
      ftc_pkg::ST_EMIT: begin
        if (n < 5'd3) begin
          res <= '{a: '0, b: '0, c: '0, tvalid: 1'b0, last: 1'b1};
        end else begin
          res.a <= vs[0];
          res.b <= vs[4'(tri_k) + 4'd1];
          res.c <= vs[4'(tri_k) + 4'd2];
          res.tvalid <= 1'b1;
          res.last <= (tri_k + 3'd1 == ntri);
        end
      end
      ftc_pkg::ST_WAIT: if (res_ready) tri_k <= tri_k + 3'd1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/ftc_checker.sv =====
// Port-level checker for the frustum clipper, bound to the top level.
`default_nettype none
module ftc_port_checks (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic triangle_valid,
  input wire logic last_triangle,
  input wire logic signed [31:0] out_a_x
);
  // a clipped-away word is always the last one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !triangle_valid |-> last_triangle) else $error("empty not last");
  // a clipped-away word carries zero in out_a_x
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !triangle_valid |-> out_a_x == 32'sd0) else $error("empty nonzero");
  // stalled word stays valid with last_triangle unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(last_triangle))
    else $error("output dropped");
endmodule

bind frustum_triangle_clipper ftc_port_checks u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .triangle_valid(triangle_valid), .last_triangle(last_triangle), .out_a_x(out_a_x)
);
`default_nettype wire
